// ----- src/csm_pkg.sv -----
// package: shared widths, register codes, cell control type and byte folding
`timescale 1ns / 1ps

package csm_pkg;

  localparam int BYTE_W        = 8;
  localparam int PATTERN_CAP   = 32;
  localparam int PATTERN_WORDS = 4;
  localparam int WORD_BYTES    = 8;
  localparam int CFG_DATA_W    = 64;
  localparam int CFG_INDEX_W   = 3;
  localparam int LEN_W         = 6;
  localparam int COUNT_W       = 7;

  localparam logic [COUNT_W-1:0] COUNT_SAT = 7'd127;

  localparam int DEF_WINDOW_BYTES = 32;
  localparam int DEF_HAYSTACK_MAX = 64;

  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_A  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_B  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_C  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_D  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LEN = 3'd4;

  localparam logic [BYTE_W-1:0] CHAR_UPPER_A = 8'h41;
  localparam logic [BYTE_W-1:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [BYTE_W-1:0] CASE_OFFSET  = 8'd32;

  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctrl_t;

  function automatic logic [BYTE_W-1:0] fold_byte(input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] r;
    r = b;
    if (b >= CHAR_UPPER_A && b <= CHAR_UPPER_Z) begin
      r = b + CASE_OFFSET;
    end
    return r;
  endfunction

endpackage

// ----- src/csm_channels.sv -----
// interfaces: haystack byte channel and match result channel
`timescale 1ns / 1ps

interface csm_hay_if
  import csm_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] hay_byte;
  logic              last_byte;

  modport source (output valid, hay_byte, last_byte, input ready);
  modport sink   (input valid, hay_byte, last_byte, output ready);
endinterface

interface csm_match_if;
  logic valid;
  logic ready;
  logic match_found;

  modport source (output valid, match_found, input ready);
  modport sink   (input valid, match_found, output ready);
endinterface

// ----- src/csm_cell.sv -----
// one pattern position: partial match flag handed on to the next cell
`timescale 1ns / 1ps

module csm_cell
  import csm_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  cell_ctrl_t        ctrl,
  input  logic [BYTE_W-1:0] hay_byte,
  input  logic [BYTE_W-1:0] pattern_byte,
  input  logic              prev_flag,
  input  logic              tail,
  output logic              flag,
  output logic              hit
);

  logic flag_next;

  assign flag_next = prev_flag && (hay_byte == pattern_byte);
  assign hit       = ctrl.shift && tail && flag_next;

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      flag <= 1'b0;
    end else if (ctrl.shift) begin
      flag <= flag_next;
    end
  end

endmodule

// ----- src/case_folding_substring_matcher.sv -----
// top level: pattern registers, row of match cells, haystack counter, result register
`timescale 1ns / 1ps

// Takes one haystack byte per cycle, folds A-Z to lower case and feeds it to
// a row of cells, one per pattern position, each holding a flag that says the
// bytes so far end in the pattern prefix up to that position; every cell
// updates in the cycle a byte within the first HAYSTACK_MAX is taken, so the
// block sustains one byte per cycle while no verdict waits. The verdict for a
// haystack is registered and offered on the result channel the cycle after its
// last byte; a waiting verdict only holds off the next haystack byte while the
// result channel stalls. The user must write pattern registers through the cfg
// port only while no haystack is in flight; the block does not enforce this.
module case_folding_substring_matcher
  import csm_pkg::*;
#(
  parameter int WINDOW_BYTES = DEF_WINDOW_BYTES,
  parameter int HAYSTACK_MAX = DEF_HAYSTACK_MAX
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  csm_hay_if.sink                hay,
  csm_match_if.source            result
);

  localparam int CELLS = (WINDOW_BYTES < PATTERN_CAP) ? WINDOW_BYTES : PATTERN_CAP;

  logic [CFG_DATA_W-1:0] pattern_words [PATTERN_WORDS];
  logic [LEN_W-1:0]      pattern_length;
  logic [LEN_W-1:0]      cmp_len;

  logic [COUNT_W-1:0]    bytes_seen;
  logic [COUNT_W-1:0]    bytes_seen_next;
  logic                  hit_seen;
  logic                  out_valid;
  logic                  out_match;

  logic                  accept;
  logic                  in_window;
  logic                  cur_hit;
  logic                  verdict;
  logic [BYTE_W-1:0]     folded;
  cell_ctrl_t            ctrl;
  logic [CELLS-1:0]      flags;
  logic [CELLS-1:0]      hits;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int w = 0; w < PATTERN_WORDS; w++) begin
        pattern_words[w] <= '0;
      end
      pattern_length <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PATTERN_A:   pattern_words[0] <= cfg_data;
        REG_PATTERN_B:   pattern_words[1] <= cfg_data;
        REG_PATTERN_C:   pattern_words[2] <= cfg_data;
        REG_PATTERN_D:   pattern_words[3] <= cfg_data;
        REG_PATTERN_LEN: pattern_length   <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign cmp_len   = (pattern_length > LEN_W'(CELLS)) ? LEN_W'(CELLS) : pattern_length;
  assign accept    = hay.valid && hay.ready;
  assign in_window = bytes_seen < COUNT_W'(HAYSTACK_MAX);
  assign folded    = fold_byte(hay.hay_byte);
  assign ctrl.shift = accept && in_window;
  assign ctrl.clear = accept && hay.last_byte;

  for (genvar k = 0; k < CELLS; k++) begin : g_cell
    logic prev_flag;
    logic tail;

    if (k == 0) begin : g_head
      assign prev_flag = 1'b1;
    end else begin : g_link
      assign prev_flag = flags[k-1];
    end

    assign tail = (cmp_len == LEN_W'(k + 1));

    csm_cell u_cell (
      .clk          (clk),
      .rst          (rst),
      .ctrl         (ctrl),
      .hay_byte     (folded),
      .pattern_byte (pattern_words[k / WORD_BYTES][(k % WORD_BYTES) * BYTE_W +: BYTE_W]),
      .prev_flag    (prev_flag),
      .tail         (tail),
      .flag         (flags[k]),
      .hit          (hits[k])
    );
  end

  assign cur_hit         = |hits;
  assign bytes_seen_next = (bytes_seen == COUNT_SAT) ? COUNT_SAT : bytes_seen + 1'b1;
  assign verdict         = (hit_seen || cur_hit) && (pattern_length != '0) &&
                           ({1'b0, pattern_length} <= bytes_seen_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_seen <= '0;
      hit_seen   <= 1'b0;
    end else if (accept) begin
      if (hay.last_byte) begin
        bytes_seen <= '0;
        hit_seen   <= 1'b0;
      end else begin
        bytes_seen <= bytes_seen_next;
        hit_seen   <= hit_seen || cur_hit;
      end
    end
  end

  // verdict register between the two channels
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.clear) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      out_match <= verdict;
    end
  end

  assign hay.ready          = !out_valid || result.ready;
  assign result.valid       = out_valid;
  assign result.match_found = out_match;

endmodule
